>>> rtl/cpclip_pkg.sv
// shared constants, types and command structs for the polygon clipper
package cpclip_pkg;

    localparam int MAX_VERTS = 128;
    localparam int VIDX_W    = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);
    localparam int ADDR_W    = VIDX_W + 1;
    localparam int ACC_W     = 68 + CNT_W;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 15;

    localparam logic [CNT_W-1:0]     MAX_CNT        = CNT_W'(MAX_VERTS);
    localparam logic [STEP_W-1:0]    LAST_STEP      = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        WR_CORNER = 2'd0,
        WR_CROSS  = 2'd1,
        WR_QVTX   = 2'd2
    } t_wr_src;

    typedef enum logic [1:0] {
        MUL_SIDE1 = 2'd0,
        MUL_SIDE2 = 2'd1,
        MUL_AREA1 = 2'd2,
        MUL_AREA2 = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic              in_load;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_wr_src           wr_src;
        logic [1:0]        corner;
        logic              cap_q;
        logic              cap_v0;
        logic              q_to_p;
        t_mul_sel          mul_sel;
        logic              p1_we;
        logic              p2_we;
        logic              diff_we;
        logic              acc_clr;
        logic              acc_add;
        logic              lr_init;
        logic              lr_coord;
        logic              lr_mul;
        logic              lr_divi;
        logic              lr_div;
        logic              lr_store;
        logic              res_load;
    } t_cmd;

    typedef struct packed {
        logic cp_neg;
        logic cq_neg;
    } t_sts;

endpackage

>>> rtl/cpclip_dp.sv
// datapath: vertex memory, shared multiplier, serial crossing divider, area accumulator
module cpclip_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cpclip_pkg::t_cmd                i_cmd,
    input  logic [127:0]                    i_line,
    input  logic                            i_cfg_we,
    input  logic [cpclip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpclip_pkg::CFG_W-1:0]    i_cfg_wdata,
    output cpclip_pkg::t_sts                o_sts,
    output logic [47:0]                     o_area
);

    function automatic logic signed [32:0] sx(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic [66:0] abs67(input logic signed [66:0] v);
        return v[66] ? 67'(-v) : 67'(v);
    endfunction

    logic [63:0] r_mem [2*cpclip_pkg::MAX_VERTS];
    logic [63:0] r_rdata;
    logic [63:0] w_wdata;

    logic [cpclip_pkg::CFG_W-1:0] r_box_w, r_box_h;
    logic [31:0] r_ax, r_ay, r_bx, r_by;
    logic [31:0] r_px, r_py, r_qx, r_qy, r_v0x, r_v0y, r_cx, r_cy;
    logic signed [65:0] r_p1, r_p2;
    logic signed [66:0] r_diff, r_cp;
    logic [cpclip_pkg::ACC_W-1:0] r_acc;

    logic        r_neg;
    logic [31:0] r_ud, r_quo;
    logic [97:0] r_mcand, r_num;
    logic [67:0] r_den, r_rem;

    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic [31:0]        w_lp, w_lq, w_res;
    logic signed [32:0] w_d;
    logic [68:0]        w_t;
    logic [31:0]        w_w, w_h;

    assign w_w = {1'b0, r_box_w, 16'h0000};
    assign w_h = {1'b0, r_box_h, 16'h0000};

    always_comb begin
        case (i_cmd.wr_src)
            cpclip_pkg::WR_CORNER: begin
                case (i_cmd.corner)
                    2'd0:    w_wdata = 64'h0;
                    2'd1:    w_wdata = {32'h0, w_h};
                    2'd2:    w_wdata = {w_w, w_h};
                    default: w_wdata = {w_w, 32'h0};
                endcase
            end
            cpclip_pkg::WR_CROSS: w_wdata = {r_cx, r_cy};
            default:              w_wdata = {r_qx, r_qy};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= w_wdata;
        end
        r_rdata <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w <= cpclip_pkg::CFG_W'(10);
            r_box_h <= cpclip_pkg::CFG_W'(10);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cpclip_pkg::CFG_BOX_WIDTH) begin
                r_box_w <= i_cfg_wdata;
            end else begin
                r_box_h <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            cpclip_pkg::MUL_SIDE1: begin
                w_ma = sx(r_qx) - sx(r_ax);
                w_mb = sx(r_by) - sx(r_ay);
            end
            cpclip_pkg::MUL_SIDE2: begin
                w_ma = sx(r_bx) - sx(r_ax);
                w_mb = sx(r_qy) - sx(r_ay);
            end
            cpclip_pkg::MUL_AREA1: begin
                w_ma = sx(r_v0y) - sx(r_py);
                w_mb = sx(r_qx) - sx(r_px);
            end
            default: begin
                w_ma = sx(r_qy) - sx(r_py);
                w_mb = sx(r_v0x) - sx(r_px);
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    assign w_lp  = i_cmd.lr_coord ? r_py : r_px;
    assign w_lq  = i_cmd.lr_coord ? r_qy : r_qx;
    assign w_d   = sx(w_lq) - sx(w_lp);
    assign w_t   = {r_rem, r_num[97]};
    assign w_res = r_neg ? (w_lp - r_quo) : (w_lp + r_quo);

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_ax <= i_line[31:0];
            r_ay <= i_line[63:32];
            r_bx <= i_line[95:64];
            r_by <= i_line[127:96];
        end
        if (i_cmd.q_to_p) begin
            r_px <= r_qx;
            r_py <= r_qy;
            r_cp <= r_diff;
        end
        if (i_cmd.cap_q) begin
            r_qx <= r_rdata[63:32];
            r_qy <= r_rdata[31:0];
        end
        if (i_cmd.cap_v0) begin
            r_v0x <= r_rdata[63:32];
            r_v0y <= r_rdata[31:0];
        end
        if (i_cmd.p1_we) begin
            r_p1 <= w_prod;
        end
        if (i_cmd.p2_we) begin
            r_p2 <= w_prod;
        end
        if (i_cmd.diff_we) begin
            r_diff <= 67'(r_p1) - 67'(r_p2);
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + cpclip_pkg::ACC_W'(abs67(r_diff));
        end
        if (i_cmd.lr_init) begin
            r_neg   <= w_d[32];
            r_ud    <= w_d[32] ? 32'(-w_d) : 32'(w_d);
            r_mcand <= 98'(abs67(r_cp));
            r_num   <= '0;
            r_den   <= 68'(abs67(r_cp)) + 68'(abs67(r_diff));
        end
        if (i_cmd.lr_mul) begin
            if (r_ud[0]) begin
                r_num <= r_num + r_mcand;
            end
            r_mcand <= {r_mcand[96:0], 1'b0};
            r_ud    <= {1'b0, r_ud[31:1]};
        end
        if (i_cmd.lr_divi) begin
            r_rem <= 68'(r_num[97:32]);
            r_num <= {r_num[65:0], 32'h0};
            r_quo <= '0;
        end
        if (i_cmd.lr_div) begin
            if (w_t >= {1'b0, r_den}) begin
                r_rem <= 68'(w_t - {1'b0, r_den});
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_t[67:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
            r_num <= {r_num[96:0], 1'b0};
        end
        if (i_cmd.lr_store) begin
            if (i_cmd.lr_coord) begin
                r_cy <= w_res;
            end else begin
                r_cx <= w_res;
            end
        end
    end

    assign o_sts.cp_neg = r_cp[66];
    assign o_sts.cq_neg = r_diff[66];

    // area is half the fan sum, truncated to q32.16 and saturated
    assign o_area = (|r_acc[cpclip_pkg::ACC_W-1:65]) ? 48'hFFFF_FFFF_FFFF : r_acc[64:17];

endmodule

>>> rtl/cpclip_ctrl.sv
// controller: sequences box load, clip walk, crossing division and area sweep
module cpclip_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_func,
    input  logic             i_out_free,
    input  cpclip_pkg::t_sts i_sts,
    output logic             o_in_ready,
    output cpclip_pkg::t_cmd o_cmd,
    output logic [7:0]       o_count,
    output logic             o_ovf
);

    typedef enum logic [26:0] {
        ST_IDLE  = 27'd1 << 0,
        ST_LOAD  = 27'd1 << 1,
        ST_CRD0  = 27'd1 << 2,
        ST_CCAP0 = 27'd1 << 3,
        ST_SIDE1 = 27'd1 << 4,
        ST_SIDE2 = 27'd1 << 5,
        ST_SIDE3 = 27'd1 << 6,
        ST_CNEXT = 27'd1 << 7,
        ST_CCAPQ = 27'd1 << 8,
        ST_CDEC  = 27'd1 << 9,
        ST_LINIT = 27'd1 << 10,
        ST_LMUL  = 27'd1 << 11,
        ST_LDIVI = 27'd1 << 12,
        ST_LDIV  = 27'd1 << 13,
        ST_LSTOR = 27'd1 << 14,
        ST_EMITX = 27'd1 << 15,
        ST_EMITQ = 27'd1 << 16,
        ST_CEND  = 27'd1 << 17,
        ST_ARD0  = 27'd1 << 18,
        ST_ACAP0 = 27'd1 << 19,
        ST_ACAP1 = 27'd1 << 20,
        ST_ACAPN = 27'd1 << 21,
        ST_AM1   = 27'd1 << 22,
        ST_AM2   = 27'd1 << 23,
        ST_ASUB  = 27'd1 << 24,
        ST_AACC  = 27'd1 << 25,
        ST_DONE  = 27'd1 << 26
    } t_state;

    function automatic logic [cpclip_pkg::ADDR_W-1:0] vaddr(
        input logic                         bank,
        input logic [cpclip_pkg::CNT_W-1:0] idx
    );
        return {bank, idx[cpclip_pkg::VIDX_W-1:0]};
    endfunction

    t_state r_state, n_state;
    logic   r_func, n_func;
    logic   r_needs_init, n_needs_init;
    logic   r_lb, n_lb;
    logic   r_ovf, n_ovf;
    logic   r_first, n_first;
    logic   r_coord, n_coord;
    logic [1:0] r_k, n_k;
    logic [cpclip_pkg::STEP_W-1:0] r_step, n_step;
    logic [cpclip_pkg::CNT_W-1:0]  r_count, n_count, r_out_n, n_out_n, r_i, n_i;
    logic [cpclip_pkg::CNT_W-1:0]  w_i1, w_i2;
    logic w_room;

    assign w_i1   = cpclip_pkg::CNT_W'(r_i + 1);
    assign w_i2   = cpclip_pkg::CNT_W'(r_i + 2);
    assign w_room = (r_out_n < cpclip_pkg::MAX_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_needs_init <= 1'b1;
            r_lb         <= 1'b0;
            r_count      <= cpclip_pkg::CNT_W'(4);
            r_ovf        <= 1'b0;
            r_func       <= 1'b0;
            r_first      <= 1'b0;
            r_coord      <= 1'b0;
            r_k          <= '0;
            r_step       <= '0;
            r_out_n      <= '0;
            r_i          <= '0;
        end else begin
            r_state      <= n_state;
            r_needs_init <= n_needs_init;
            r_lb         <= n_lb;
            r_count      <= n_count;
            r_ovf        <= n_ovf;
            r_func       <= n_func;
            r_first      <= n_first;
            r_coord      <= n_coord;
            r_k          <= n_k;
            r_step       <= n_step;
            r_out_n      <= n_out_n;
            r_i          <= n_i;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_needs_init = r_needs_init;
        n_lb         = r_lb;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_func       = r_func;
        n_first      = r_first;
        n_coord      = r_coord;
        n_k          = r_k;
        n_step       = r_step;
        n_out_n      = r_out_n;
        n_i          = r_i;
        o_cmd        = '0;
        o_cmd.wr_src  = cpclip_pkg::WR_CORNER;
        o_cmd.mul_sel = cpclip_pkg::MUL_SIDE1;
        o_cmd.lr_coord = r_coord;
        o_in_ready   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_func  = i_func;
                    n_ovf   = 1'b0;
                    n_k     = '0;
                    n_i     = '0;
                    n_out_n = '0;
                    if (r_needs_init || !i_func) begin
                        n_state = ST_LOAD;
                    end else if (r_count == '0) begin
                        n_state = ST_CEND;
                    end else begin
                        n_state = ST_CRD0;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = vaddr(r_lb, cpclip_pkg::CNT_W'(r_k));
                o_cmd.corner  = r_k;
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_count      = cpclip_pkg::CNT_W'(4);
                    n_needs_init = 1'b0;
                    n_state      = r_func ? ST_CRD0 : ST_ARD0;
                end
            end
            ST_CRD0: begin
                o_cmd.rd_addr = vaddr(r_lb, '0);
                n_state = ST_CCAP0;
            end
            ST_CCAP0: begin
                o_cmd.cap_q = 1'b1;
                n_first = 1'b1;
                n_state = ST_SIDE1;
            end
            ST_SIDE1: begin
                o_cmd.mul_sel = cpclip_pkg::MUL_SIDE1;
                o_cmd.p1_we   = 1'b1;
                n_state = ST_SIDE2;
            end
            ST_SIDE2: begin
                o_cmd.mul_sel = cpclip_pkg::MUL_SIDE2;
                o_cmd.p2_we   = 1'b1;
                n_state = ST_SIDE3;
            end
            ST_SIDE3: begin
                o_cmd.diff_we = 1'b1;
                n_state = r_first ? ST_CNEXT : ST_CDEC;
            end
            ST_CNEXT: begin
                o_cmd.q_to_p  = 1'b1;
                o_cmd.rd_addr = vaddr(r_lb, (w_i1 == r_count) ? '0 : w_i1);
                n_first = 1'b0;
                n_state = ST_CCAPQ;
            end
            ST_CCAPQ: begin
                o_cmd.cap_q = 1'b1;
                n_state = ST_SIDE1;
            end
            ST_CDEC: begin
                if (i_sts.cp_neg != i_sts.cq_neg) begin
                    n_coord = 1'b0;
                    n_state = ST_LINIT;
                end else if (!i_sts.cq_neg) begin
                    n_state = ST_EMITQ;
                end else begin
                    n_i     = w_i1;
                    n_state = (w_i1 == r_count) ? ST_CEND : ST_CNEXT;
                end
            end
            ST_LINIT: begin
                o_cmd.lr_init = 1'b1;
                n_step  = '0;
                n_state = ST_LMUL;
            end
            ST_LMUL: begin
                o_cmd.lr_mul = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == cpclip_pkg::LAST_STEP) begin
                    n_state = ST_LDIVI;
                end
            end
            ST_LDIVI: begin
                o_cmd.lr_divi = 1'b1;
                n_step  = '0;
                n_state = ST_LDIV;
            end
            ST_LDIV: begin
                o_cmd.lr_div = 1'b1;
                n_step = r_step + 1'b1;
                if (r_step == cpclip_pkg::LAST_STEP) begin
                    n_state = ST_LSTOR;
                end
            end
            ST_LSTOR: begin
                o_cmd.lr_store = 1'b1;
                if (!r_coord) begin
                    n_coord = 1'b1;
                    n_state = ST_LINIT;
                end else begin
                    n_state = ST_EMITX;
                end
            end
            ST_EMITX: begin
                o_cmd.wr_src  = cpclip_pkg::WR_CROSS;
                o_cmd.wr_addr = vaddr(!r_lb, r_out_n);
                o_cmd.wr_en   = w_room;
                if (w_room) begin
                    n_out_n = r_out_n + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                if (!i_sts.cq_neg) begin
                    n_state = ST_EMITQ;
                end else begin
                    n_i     = w_i1;
                    n_state = (w_i1 == r_count) ? ST_CEND : ST_CNEXT;
                end
            end
            ST_EMITQ: begin
                o_cmd.wr_src  = cpclip_pkg::WR_QVTX;
                o_cmd.wr_addr = vaddr(!r_lb, r_out_n);
                o_cmd.wr_en   = w_room;
                if (w_room) begin
                    n_out_n = r_out_n + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
                n_i     = w_i1;
                n_state = (w_i1 == r_count) ? ST_CEND : ST_CNEXT;
            end
            ST_CEND: begin
                n_count = r_out_n;
                n_lb    = !r_lb;
                n_state = ST_ARD0;
            end
            ST_ARD0: begin
                o_cmd.acc_clr = 1'b1;
                o_cmd.rd_addr = vaddr(r_lb, '0);
                n_state = (r_count < cpclip_pkg::CNT_W'(3)) ? ST_DONE : ST_ACAP0;
            end
            ST_ACAP0: begin
                o_cmd.cap_v0  = 1'b1;
                o_cmd.rd_addr = vaddr(r_lb, cpclip_pkg::CNT_W'(1));
                n_state = ST_ACAP1;
            end
            ST_ACAP1: begin
                o_cmd.cap_q   = 1'b1;
                o_cmd.rd_addr = vaddr(r_lb, cpclip_pkg::CNT_W'(2));
                n_i     = cpclip_pkg::CNT_W'(1);
                n_state = ST_ACAPN;
            end
            ST_ACAPN: begin
                o_cmd.q_to_p = 1'b1;
                o_cmd.cap_q  = 1'b1;
                n_state = ST_AM1;
            end
            ST_AM1: begin
                o_cmd.mul_sel = cpclip_pkg::MUL_AREA1;
                o_cmd.p1_we   = 1'b1;
                n_state = ST_AM2;
            end
            ST_AM2: begin
                o_cmd.mul_sel = cpclip_pkg::MUL_AREA2;
                o_cmd.p2_we   = 1'b1;
                n_state = ST_ASUB;
            end
            ST_ASUB: begin
                o_cmd.diff_we = 1'b1;
                n_state = ST_AACC;
            end
            ST_AACC: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.rd_addr = vaddr(r_lb, w_i2);
                n_i     = w_i1;
                n_state = (w_i2 == r_count) ? ST_DONE : ST_ACAPN;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_count = 8'(r_count);
    assign o_ovf   = r_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cpclip_pkg::MAX_CNT)
        else $error("live vertex count beyond store size");

    a_clip_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en && (r_state != ST_LOAD) |-> o_cmd.wr_addr[cpclip_pkg::ADDR_W-1] != r_lb)
        else $error("clip output written into live bank");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf && (r_state != ST_IDLE) |-> r_out_n == cpclip_pkg::MAX_CNT || r_state == ST_CEND
            || r_state == ST_ARD0 || r_state == ST_ACAP0 || r_state == ST_ACAP1
            || r_state == ST_ACAPN || r_state == ST_AM1 || r_state == ST_AM2
            || r_state == ST_ASUB || r_state == ST_AACC || r_state == ST_DONE)
        else $error("overflow flagged with room left");

endmodule

>>> rtl/convex_polygon_halfplane_clip_area.sv
// top level: convex polygon half-plane clipper with area readout
// One request at a time is taken in, and only while the controller is idle. A restart loads
// the box. A clip walks each edge of the live polygon, writes each output vertex, and divides
// out a crossing point for each edge that crosses the line (two 32-step shift-add
// multiplies and two 32-step restoring divides per crossing point). An area sweep over the
// vertices left ends every request, with area zero when fewer than three are left.
// The first request after reset also loads the box.
// The datapath has a single 33x33 multiplier and a single read port on the vertex memory.
// The result waits in an output register, so the next request is taken while it is still
// unread; a finished request waits while that register is still full.
module convex_polygon_halfplane_clip_area (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [127:0]                     s_axis_tdata,  // line_ax, line_ay, line_bx, line_by
    input  logic                             s_axis_tuser,  // func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [63:0]                      m_axis_tdata,  // area, vertex_count, overflow
    input  logic                             i_cfg_we,
    input  logic [cpclip_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cpclip_pkg::CFG_W-1:0]     i_cfg_wdata
);

    cpclip_pkg::t_cmd w_cmd;
    cpclip_pkg::t_sts w_sts;
    logic [47:0] w_area;
    logic [7:0]  w_count;
    logic        w_ovf, w_out_free;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    assign w_out_free = !r_out_valid || m_axis_tready;

    cpclip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser),
        .i_out_free (w_out_free),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .o_count    (w_count),
        .o_ovf      (w_ovf)
    );

    cpclip_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_line      (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_sts       (w_sts),
        .o_area      (w_area)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.res_load) begin
            r_out_data <= {7'b0, w_ovf, w_count, w_area};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

>>> verif/tb_convex_polygon_halfplane_clip_area.sv
// testbench for the polygon clipper: random and directed clip requests against a bit-exact predictor
module tb_convex_polygon_halfplane_clip_area;

    localparam int  FUNC_RESTART = 0;
    localparam int  FUNC_CLIP    = 1;
    localparam int  CYCLE_LIMIT  = 10_000_000;
    localparam int  NVERT        = cpclip_pkg::MAX_VERTS;

    typedef struct {
        logic        func;
        logic [31:0] ax, ay, bx, by;
    } t_clip_item;

    typedef struct {
        logic [47:0] area;
        logic [7:0]  cnt;
        logic        ovf;
    } t_clip_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;  // line_ax, line_ay, line_bx, line_by
    logic         s_axis_tuser = 1'b0;  // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;  // area, vertex_count, overflow
    logic                                 i_cfg_we = 1'b0;
    logic [cpclip_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [cpclip_pkg::CFG_W-1:0]         i_cfg_wdata = '0;

    convex_polygon_halfplane_clip_area i_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_clip_item   pending_requests[$];
    t_clip_result expected_results[$];
    int  errors = 0;
    int  cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_go = 1'b0;
    bit  hold_seen = 1'b0;
    int  stall_left = 0;

    // predictor state
    longint poly_x[2*NVERT];
    longint poly_y[2*NVERT];
    int     live_n = 4;
    int     bank = 0;
    bit     box_pending = 1'b1;
    int     box_w = 10;
    int     box_h = 10;
    longint lax, lay, lbx, lby;

    function automatic logic signed [127:0] side_of_line(longint px, longint py);
        logic signed [127:0] a, b, c, d;
        a = px - lax;
        b = lby - lay;
        c = lbx - lax;
        d = py - lay;
        return a * b - c * d;
    endfunction

    function automatic logic [127:0] mag(logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint crossing(longint p, longint q, logic [127:0] cp_mag,
                                        logic [127:0] den);
        longint d;
        logic [127:0] ud, quo;
        d = q - p;
        ud = d < 0 ? -d : d;
        quo = (cp_mag * ud) / den;
        return d < 0 ? p - longint'(quo[63:0]) : p + longint'(quo[63:0]);
    endfunction

    task automatic load_box();
        int b;
        b = bank * NVERT;
        poly_x[b] = 0;                   poly_y[b] = 0;
        poly_x[b+1] = 0;                 poly_y[b+1] = longint'(box_h) * 65536;
        poly_x[b+2] = longint'(box_w) * 65536; poly_y[b+2] = longint'(box_h) * 65536;
        poly_x[b+3] = longint'(box_w) * 65536; poly_y[b+3] = 0;
        live_n = 4;
        box_pending = 1'b0;
    endtask

    task automatic predict_clip_result(t_clip_item it);
        int src, dst, n, j;
        bit ovf, lp, lq;
        logic signed [127:0] cp, cq, t, y0d, xnd, ynd, x0d;
        logic [127:0] a, s;
        longint nx, ny;
        t_clip_result r;
        ovf = 1'b0;
        if (box_pending || it.func == FUNC_RESTART) load_box();
        if (it.func == FUNC_CLIP) begin
            lax = longint'($signed(it.ax)); lay = longint'($signed(it.ay));
            lbx = longint'($signed(it.bx)); lby = longint'($signed(it.by));
            src = bank * NVERT;
            dst = (bank ^ 1) * NVERT;
            n = 0;
            for (int i = 0; i < live_n; i++) begin
                j = (i + 1 == live_n) ? 0 : i + 1;
                cp = side_of_line(poly_x[src+i], poly_y[src+i]);
                cq = side_of_line(poly_x[src+j], poly_y[src+j]);
                lp = cp < 0;
                lq = cq < 0;
                if (lp && lq) continue;
                if (lp != lq) begin
                    a = mag(cp);
                    nx = crossing(poly_x[src+i], poly_x[src+j], a, a + mag(cq));
                    ny = crossing(poly_y[src+i], poly_y[src+j], a, a + mag(cq));
                    if (n < NVERT) begin
                        poly_x[dst+n] = nx; poly_y[dst+n] = ny; n++;
                    end else ovf = 1'b1;
                end
                if (!lq) begin
                    if (n < NVERT) begin
                        poly_x[dst+n] = poly_x[src+j]; poly_y[dst+n] = poly_y[src+j]; n++;
                    end else ovf = 1'b1;
                end
            end
            live_n = n;
            bank ^= 1;
        end
        s = '0;
        src = bank * NVERT;
        for (int i = 1; i + 1 < live_n; i++) begin
            y0d = poly_y[src] - poly_y[src+i];
            xnd = poly_x[src+i+1] - poly_x[src+i];
            ynd = poly_y[src+i+1] - poly_y[src+i];
            x0d = poly_x[src] - poly_x[src+i];
            t = y0d * xnd - ynd * x0d;
            s = s + mag(t);
        end
        s = s >> 17;
        r.area = (s > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
        r.cnt = live_n[7:0];
        r.ovf = ovf;
        expected_results.push_back(r);
    endtask

    // request driver
    always @(posedge i_clk) begin
        bit took;
        t_clip_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            took = s_axis_tvalid && s_axis_tready;
            if (took) predict_clip_result('{s_axis_tuser, s_axis_tdata[31:0],
                s_axis_tdata[63:32], s_axis_tdata[95:64], s_axis_tdata[127:96]});
            if (!s_axis_tvalid || took) begin
                if (pending_requests.size() > 0 && (!idle_on || $urandom_range(99) >= 37)) begin
                    it = pending_requests.pop_front();
                    s_axis_tuser <= it.func;
                    s_axis_tdata <= {it.by, it.bx, it.ay, it.ax};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side: ready pattern and long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            stall_left <= 400;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !idle_on || $urandom_range(99) >= 37;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_clip_result e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
            end else begin
                e = expected_results.pop_front();
                if (m_axis_tdata[47:0] !== e.area || m_axis_tdata[55:48] !== e.cnt ||
                    m_axis_tdata[56] !== e.ovf) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp area %h cnt %0d ovf %b, got area %h cnt %0d ovf %b",
                                 e.area, e.cnt, e.ovf, m_axis_tdata[47:0],
                                 m_axis_tdata[55:48], m_axis_tdata[56]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("** convex_polygon_halfplane_clip_area: FAILED **");
            $finish;
        end
    end

    task automatic add_request(int func, longint ax, longint ay, longint bx, longint by);
        t_clip_item it;
        it.func = func[0];
        it.ax = ax[31:0]; it.ay = ay[31:0]; it.bx = bx[31:0]; it.by = by[31:0];
        pending_requests.push_back(it);
    endtask

    // checked between edges so that every update of the edge has settled
    task automatic wait_idle();
        while (pending_requests.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [cpclip_pkg::CFG_IDX_W-1:0] idx, int value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value[cpclip_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cpclip_pkg::CFG_BOX_WIDTH) box_w = value;
        else box_h = value;
    endtask

    function automatic longint rand_coord(int span);
        if ($urandom_range(9) < 3) return longint'($signed($urandom()));
        return longint'($urandom_range(span + 2)) * 65536 + $urandom_range(65535) - 65536;
    endfunction

    task automatic random_phase(int n, int span);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9) == 0)
                add_request(FUNC_RESTART, $urandom(), $urandom(), $urandom(), $urandom());
            else
                add_request(FUNC_CLIP, rand_coord(span), rand_coord(span),
                            rand_coord(span), rand_coord(span));
        end
    endtask

    localparam longint U = 65536;
    localparam longint SMIN = -64'sd2147483648;
    localparam longint SMAX = 64'sd2147483647;

    initial begin
        real th, cx, r, tx, ty;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // first request clips the reset box
        add_request(FUNC_CLIP, 0, 5*U, 10*U, 5*U);
        add_request(FUNC_RESTART, 0, 0, 0, 0);
        add_request(FUNC_CLIP, 10*U, 5*U, 0, 5*U);
        add_request(FUNC_CLIP, 3*U, 3*U, 3*U, 3*U);
        add_request(FUNC_RESTART, SMAX, SMAX, SMAX, SMAX);
        add_request(FUNC_CLIP, 0, 0, 0, 10*U);
        add_request(FUNC_CLIP, 0, 10*U, 0, 0);
        add_request(FUNC_CLIP, 0, 0, 1, 1);
        add_request(FUNC_CLIP, 0, 0, 1, 1);
        add_request(FUNC_RESTART, 0, 0, 0, 0);
        add_request(FUNC_CLIP, SMIN, SMIN, SMAX, SMAX);
        add_request(FUNC_CLIP, SMAX, SMIN, SMIN, SMAX);
        add_request(FUNC_RESTART, 0, 0, 0, 0);
        add_request(FUNC_CLIP, SMIN, SMAX, SMAX, SMIN);
        add_request(FUNC_CLIP, 1, 3*U+7, 9*U+5, 1);
        write_reg(cpclip_pkg::CFG_BOX_WIDTH, 0);
        write_reg(cpclip_pkg::CFG_BOX_HEIGHT, 0);
        add_request(FUNC_RESTART, 0, 0, 0, 0);
        add_request(FUNC_CLIP, 0, 0, U, U);
        write_reg(cpclip_pkg::CFG_BOX_WIDTH, 32767);
        write_reg(cpclip_pkg::CFG_BOX_HEIGHT, 32767);
        add_request(FUNC_RESTART, 0, 0, 0, 0);
        add_request(FUNC_CLIP, SMIN, 0, SMAX, SMAX);
        add_request(FUNC_RESTART, 0, 0, 0, 0);
        add_request(FUNC_CLIP, SMAX, SMAX, SMIN, SMIN);
        // tangent cuts around a circle to grow the polygon past the store
        add_request(FUNC_RESTART, 0, 0, 0, 0);
        cx = 16383.0 * 65536.0;
        r = 16000.0 * 65536.0;
        for (int k = 0; k < 140; k++) begin
            th = 6.283185307 * k / 140.0;
            tx = cx + r * $cos(th);
            ty = cx + r * $sin(th);
            add_request(FUNC_CLIP, $rtoi(tx), $rtoi(ty),
                        $rtoi(tx + 65536000.0 * $sin(th)), $rtoi(ty - 65536000.0 * $cos(th)));
        end
        wait_idle();
        write_reg(cpclip_pkg::CFG_BOX_WIDTH, 37);
        write_reg(cpclip_pkg::CFG_BOX_HEIGHT, 12);
        random_phase(200, 40);
        hold_go = ~hold_go;
        wait_idle();
        write_reg(cpclip_pkg::CFG_BOX_WIDTH, 1);
        write_reg(cpclip_pkg::CFG_BOX_HEIGHT, 3000);
        idle_on = 1'b0;
        random_phase(200, 3000);
        wait_idle();
        idle_on = 1'b1;
        write_reg(cpclip_pkg::CFG_BOX_WIDTH, $urandom_range(32767));
        write_reg(cpclip_pkg::CFG_BOX_HEIGHT, $urandom_range(32767));
        random_phase(200, box_w > box_h ? box_w : box_h);
        wait_idle();
        write_reg(cpclip_pkg::CFG_BOX_WIDTH, 10);
        write_reg(cpclip_pkg::CFG_BOX_HEIGHT, 10);
        random_phase(190, 10);
        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("** convex_polygon_halfplane_clip_area: PASSED **");
        else
            $display("** convex_polygon_halfplane_clip_area: FAILED **");
        $finish;
    end

endmodule
